>>> rtl/core/jdc_pkg.sv
// Package for the day number / calendar date converter.
// Holds field widths, the fixed-point reciprocal constants and the month tables.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package jdc_pkg;

  localparam int FUNC_W = 1;
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int DN_W   = 23;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_TO_NUMBER = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_TO_DATE   = 1'b1;

  // Julian day number, one wider than the stored day number
  localparam int Z_W = DN_W + 1;
  localparam logic [Z_W-1:0] GREG_START_JDN = 24'd2299161;

  localparam logic [YEAR_W-1:0] YEAR_MAX_V = 14'd9999;

  // Century count: floor(y / 100) = (y * 10486) >> 20, exact for y < 16384
  localparam int            CENT_W   = 8;
  localparam logic [13:0]   CENT_MUL = 14'd10486;
  localparam int            CENT_SH  = 20;

  // Gregorian count: floor(n / 146097) = (n * 30103606) >> 42, exact for n < 2^25
  localparam int            GN_W   = 25;
  localparam int            G_W    = 8;
  localparam logic [24:0]   GC_MUL = 25'd30103606;
  localparam int            GC_SH  = 42;
  localparam logic [25:0]   GC_OFS = 26'd7468865;

  // Year count: floor(n / 7305) = (n * 301029878) >> 41, exact for n < 2^28
  localparam int            CN_W   = 28;
  localparam int            C_W    = 15;
  localparam logic [28:0]   CY_MUL = 29'd301029878;
  localparam int            CY_SH  = 41;
  localparam logic [27:0]   CY_OFS = 28'd2442;

  // Day within the shifted year, month term and month code widths
  localparam int R_W  = 9;
  localparam int MT_W = 9;
  localparam int E_W  = 4;

  // floor(30.6001 * k) for k = 0 .. 16
  function automatic logic [MT_W-1:0] mon_term(input logic [4:0] k);
    logic [MT_W-1:0] v;
    case (k)
      5'd0:    v = 9'd0;
      5'd1:    v = 9'd30;
      5'd2:    v = 9'd61;
      5'd3:    v = 9'd91;
      5'd4:    v = 9'd122;
      5'd5:    v = 9'd153;
      5'd6:    v = 9'd183;
      5'd7:    v = 9'd214;
      5'd8:    v = 9'd244;
      5'd9:    v = 9'd275;
      5'd10:   v = 9'd306;
      5'd11:   v = 9'd336;
      5'd12:   v = 9'd367;
      5'd13:   v = 9'd397;
      5'd14:   v = 9'd428;
      5'd15:   v = 9'd459;
      5'd16:   v = 9'd489;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // floor(r / 30.6001): largest e whose month term lies below r
  function automatic logic [E_W-1:0] e_of(input logic [R_W-1:0] r);
    logic [E_W-1:0] e;
    e = '0;
    for (int i = 1; i < 16; i++) begin
      if (r > mon_term(5'(i))) e = 4'(i);
    end
    return e;
  endfunction

endpackage

>>> rtl/core/jdc_if.sv
// Request and result channel interfaces of the date converter.
// Depends on jdc_pkg for the field widths.
interface jdc_req_if;
  logic                        valid;
  logic                        ready;
  logic [jdc_pkg::FUNC_W-1:0]  func;
  logic [jdc_pkg::DAY_W-1:0]   day;
  logic [jdc_pkg::MON_W-1:0]   month;
  logic [jdc_pkg::YEAR_W-1:0]  year;
  logic [jdc_pkg::DN_W-1:0]    day_number;

  modport source (output valid, func, day, month, year, day_number, input ready);
  modport sink   (input valid, func, day, month, year, day_number, output ready);
endinterface

interface jdc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [jdc_pkg::DN_W-1:0]    day_number_out;
  logic [jdc_pkg::DAY_W-1:0]   day_out;
  logic [jdc_pkg::MON_W-1:0]   month_out;
  logic [jdc_pkg::YEAR_W-1:0]  year_out;
  logic                        range_error;

  modport source (output valid, day_number_out, day_out, month_out, year_out, range_error,
                  input ready);
  modport sink   (input valid, day_number_out, day_out, month_out, year_out, range_error,
                  output ready);
endinterface

>>> rtl/core/julian_day_date_converter.sv
// Day number / calendar date converter, seven-stage pipeline.
// Depends on jdc_pkg (constants, month tables) and jdc_if (jdc_req_if, jdc_rsp_if).
//
// Converts in both directions between a calendar date and a stored day number
// (Julian day number minus one). A request with func 0 turns day, month and year
// into a day number, counting January and February as months 13 and 14 of the
// year before and always applying the Gregorian century correction. A request
// with func 1 turns a day number into day, month and year, using the Julian
// calendar before Julian day 2299161 and the Gregorian calendar from then on;
// years outside 1 to 9999 are clamped to 0 or 9999. range_error flags an input
// or result year outside 1 to 9999, and the fields that a function does not
// produce read as zero. The block takes one request per clock while the result
// side is not stalled and returns the results in request order. Every
// stage has its own valid bit and hands on when the stage after it is free, so
// a stall on the result side only stops the stages that are full and empty
// stages keep taking requests. The pipe depth is set by the chain of the reverse
// conversion: the two reciprocal multiplications (Gregorian cycle and year
// count) sit in separate stages, followed by the day within the year, the month
// code and the output register; no state survives from one request to the next.
module julian_day_date_converter (
  input  logic         clk,
  input  logic         rst_n,
  jdc_req_if.sink      in_chan,
  jdc_rsp_if.source    out_chan
);

  // ---------------------------------------------------------------------------
  // Stage valid bits and enables: a stage loads when it is empty or when the
  // stage after it loads as well.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  assign en7 = !v7_r || out_chan.ready;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_chan.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_chan.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: shift January and February into the year before, look up the
  // month term, and form the Julian day number with its Gregorian offset.
  // ---------------------------------------------------------------------------
  logic                          early;
  logic [4:0]                    madj;
  logic [jdc_pkg::YEAR_W-1:0]    s1_ys_nxt;
  logic [14:0]                   s1_yp_nxt;
  logic [jdc_pkg::MT_W-1:0]      s1_mterm_nxt;
  logic                          s1_yerr_nxt;
  logic [jdc_pkg::Z_W-1:0]       s1_z_nxt;
  logic                          s1_greg_nxt;
  logic [25:0]                   gdiff;
  logic [jdc_pkg::GN_W-1:0]      s1_ng_nxt;

  always_comb begin
    early        = (in_chan.month <= 4'd2);
    madj         = early ? (5'(in_chan.month) + 5'd12) : 5'(in_chan.month);
    s1_mterm_nxt = jdc_pkg::mon_term(madj + 5'd1);
    // The century count of year -1 is zero, so clip it at zero
    s1_ys_nxt    = (early && (in_chan.year == '0)) ? '0
                 : (in_chan.year - 14'(early));
    s1_yp_nxt    = 15'(in_chan.year) + 15'd4716 - 15'(early);
    s1_yerr_nxt  = (in_chan.year == '0) || (in_chan.year > jdc_pkg::YEAR_MAX_V);
    s1_z_nxt     = 24'(in_chan.day_number) + 24'd1;
    s1_greg_nxt  = (s1_z_nxt >= jdc_pkg::GREG_START_JDN);
    gdiff        = {s1_z_nxt, 2'b00} - jdc_pkg::GC_OFS;
    s1_ng_nxt    = gdiff[jdc_pkg::GN_W-1:0];
  end

  logic [jdc_pkg::FUNC_W-1:0]    s1_fn_r;
  logic [jdc_pkg::DAY_W-1:0]     s1_day_r;
  logic [jdc_pkg::YEAR_W-1:0]    s1_ys_r;
  logic [14:0]                   s1_yp_r;
  logic [jdc_pkg::MT_W-1:0]      s1_mterm_r;
  logic                          s1_yerr_r;
  logic [jdc_pkg::Z_W-1:0]       s1_z_r;
  logic                          s1_greg_r;
  logic [jdc_pkg::GN_W-1:0]      s1_ng_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_fn_r    <= in_chan.func;
      s1_day_r   <= in_chan.day;
      s1_ys_r    <= s1_ys_nxt;
      s1_yp_r    <= s1_yp_nxt;
      s1_mterm_r <= s1_mterm_nxt;
      s1_yerr_r  <= s1_yerr_nxt;
      s1_z_r     <= s1_z_nxt;
      s1_greg_r  <= s1_greg_nxt;
      s1_ng_r    <= s1_ng_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: year term 365.25 * (y + 4716), century count and Gregorian cycle
  // count, each by a constant multiplication.
  // ---------------------------------------------------------------------------
  logic [25:0]                   yprod;
  logic [27:0]                   cprod;
  logic [49:0]                   gprod;
  logic [23:0]                   s2_yterm_nxt;
  logic [jdc_pkg::CENT_W-1:0]    s2_cent_nxt;
  logic [jdc_pkg::G_W-1:0]       s2_g_nxt;

  always_comb begin
    yprod        = 26'(s1_yp_r) * 26'd1461;
    cprod        = 28'(s1_ys_r) * 28'(jdc_pkg::CENT_MUL);
    gprod        = 50'(s1_ng_r) * 50'(jdc_pkg::GC_MUL);
    s2_yterm_nxt = yprod[25:2];
    s2_cent_nxt  = cprod[jdc_pkg::CENT_SH +: jdc_pkg::CENT_W];
    s2_g_nxt     = gprod[jdc_pkg::GC_SH +: jdc_pkg::G_W];
  end

  logic [jdc_pkg::FUNC_W-1:0]    s2_fn_r;
  logic [jdc_pkg::DAY_W-1:0]     s2_day_r;
  logic [jdc_pkg::MT_W-1:0]      s2_mterm_r;
  logic                          s2_yerr_r;
  logic [23:0]                   s2_yterm_r;
  logic [jdc_pkg::CENT_W-1:0]    s2_cent_r;
  logic [jdc_pkg::Z_W-1:0]       s2_z_r;
  logic                          s2_greg_r;
  logic [jdc_pkg::G_W-1:0]       s2_g_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_fn_r    <= s1_fn_r;
      s2_day_r   <= s1_day_r;
      s2_mterm_r <= s1_mterm_r;
      s2_yerr_r  <= s1_yerr_r;
      s2_yterm_r <= s2_yterm_nxt;
      s2_cent_r  <= s2_cent_nxt;
      s2_z_r     <= s1_z_r;
      s2_greg_r  <= s1_greg_r;
      s2_g_r     <= s2_g_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: finish the day number; for the reverse direction apply the
  // Gregorian correction and form the numerator of the year count.
  // ---------------------------------------------------------------------------
  logic [24:0]                   dsum;
  logic [jdc_pkg::DN_W-1:0]      s3_dn_nxt;
  logic [jdc_pkg::Z_W-1:0]       a_val;
  logic [jdc_pkg::Z_W-1:0]       s3_b_nxt;
  logic [jdc_pkg::CN_W-1:0]      s3_n2_nxt;

  always_comb begin
    // The year term alone keeps the sum well above zero: no clamp needed
    dsum      = 25'(s2_yterm_r) + 25'(s2_mterm_r) + 25'(s2_day_r) + 25'd2
              + 25'(s2_cent_r >> 2) - 25'(s2_cent_r) - 25'd1525;
    s3_dn_nxt = dsum[jdc_pkg::DN_W-1:0];
    a_val     = s2_greg_r ? (s2_z_r + 24'(s2_g_r) + 24'd1 - 24'(s2_g_r >> 2)) : s2_z_r;
    s3_b_nxt  = a_val + 24'd1524;
    // 20 * b - 2442, the year count numerator scaled down by five
    s3_n2_nxt = {s3_b_nxt, 4'b0000} + 28'({s3_b_nxt, 2'b00}) - jdc_pkg::CY_OFS;
  end

  logic [jdc_pkg::FUNC_W-1:0]    s3_fn_r;
  logic                          s3_yerr_r;
  logic [jdc_pkg::DN_W-1:0]      s3_dn_r;
  logic [jdc_pkg::Z_W-1:0]       s3_b_r;
  logic [jdc_pkg::CN_W-1:0]      s3_n2_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_fn_r   <= s2_fn_r;
      s3_yerr_r <= s2_yerr_r;
      s3_dn_r   <= s3_dn_nxt;
      s3_b_r    <= s3_b_nxt;
      s3_n2_r   <= s3_n2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: year count c = floor((20b - 2442) / 7305) by reciprocal.
  // ---------------------------------------------------------------------------
  logic [56:0]                   yc_prod;
  logic [jdc_pkg::C_W-1:0]       s4_c_nxt;

  always_comb begin
    yc_prod  = 57'(s3_n2_r) * 57'(jdc_pkg::CY_MUL);
    s4_c_nxt = yc_prod[jdc_pkg::CY_SH +: jdc_pkg::C_W];
  end

  logic [jdc_pkg::FUNC_W-1:0]    s4_fn_r;
  logic                          s4_yerr_r;
  logic [jdc_pkg::DN_W-1:0]      s4_dn_r;
  logic [jdc_pkg::Z_W-1:0]       s4_b_r;
  logic [jdc_pkg::C_W-1:0]       s4_c_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_fn_r   <= s3_fn_r;
      s4_yerr_r <= s3_yerr_r;
      s4_dn_r   <= s3_dn_r;
      s4_b_r    <= s3_b_r;
      s4_c_r    <= s4_c_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: day within the shifted year, b - floor(365.25 * c).
  // ---------------------------------------------------------------------------
  logic [25:0]                   dd_prod;
  logic [jdc_pkg::Z_W-1:0]       rdiff;
  logic [jdc_pkg::R_W-1:0]       s5_r_nxt;

  always_comb begin
    dd_prod  = 26'(s4_c_r) * 26'd1461;
    rdiff    = s4_b_r - dd_prod[25:2];
    s5_r_nxt = rdiff[jdc_pkg::R_W-1:0];
  end

  logic [jdc_pkg::FUNC_W-1:0]    s5_fn_r;
  logic                          s5_yerr_r;
  logic [jdc_pkg::DN_W-1:0]      s5_dn_r;
  logic [jdc_pkg::C_W-1:0]       s5_c_r;
  logic [jdc_pkg::R_W-1:0]       s5_r_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_fn_r   <= s4_fn_r;
      s5_yerr_r <= s4_yerr_r;
      s5_dn_r   <= s4_dn_r;
      s5_c_r    <= s4_c_r;
      s5_r_r    <= s5_r_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: month code e = floor(r / 30.6001) against the threshold table.
  // ---------------------------------------------------------------------------
  logic [jdc_pkg::FUNC_W-1:0]    s6_fn_r;
  logic                          s6_yerr_r;
  logic [jdc_pkg::DN_W-1:0]      s6_dn_r;
  logic [jdc_pkg::C_W-1:0]       s6_c_r;
  logic [jdc_pkg::R_W-1:0]       s6_r_r;
  logic [jdc_pkg::E_W-1:0]       s6_e_r;

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_fn_r   <= s5_fn_r;
      s6_yerr_r <= s5_yerr_r;
      s6_dn_r   <= s5_dn_r;
      s6_c_r    <= s5_c_r;
      s6_r_r    <= s5_r_r;
      s6_e_r    <= jdc_pkg::e_of(s5_r_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7, output register: day, month and clamped year, or the day number.
  // ---------------------------------------------------------------------------
  logic [jdc_pkg::R_W-1:0]       dday;
  logic [jdc_pkg::MON_W-1:0]     mon;
  logic signed [15:0]            ysg;
  logic [jdc_pkg::DN_W-1:0]      o_dn_nxt;
  logic [jdc_pkg::DAY_W-1:0]     o_day_nxt;
  logic [jdc_pkg::MON_W-1:0]     o_mon_nxt;
  logic [jdc_pkg::YEAR_W-1:0]    o_year_nxt;
  logic                          o_err_nxt;

  always_comb begin
    dday = s6_r_r - jdc_pkg::mon_term(5'(s6_e_r));
    mon  = (s6_e_r < 4'd14) ? (s6_e_r - 4'd1) : (s6_e_r - 4'd13);
    ysg  = $signed(16'(s6_c_r)) - ((mon > 4'd2) ? 16'sd4716 : 16'sd4715);
    o_dn_nxt   = '0;
    o_day_nxt  = '0;
    o_mon_nxt  = '0;
    o_year_nxt = '0;
    o_err_nxt  = 1'b0;
    if (s6_fn_r == jdc_pkg::FUNC_TO_NUMBER) begin
      o_dn_nxt  = s6_dn_r;
      o_err_nxt = s6_yerr_r;
    end else begin
      o_day_nxt = dday[jdc_pkg::DAY_W-1:0];
      o_mon_nxt = mon;
      // Clamp the year and flag it when it falls outside the calendar range
      if (ysg < 16'sd1) begin
        o_err_nxt = 1'b1;
      end else if (ysg > 16'sd9999) begin
        o_year_nxt = jdc_pkg::YEAR_MAX_V;
        o_err_nxt  = 1'b1;
      end else begin
        o_year_nxt = ysg[jdc_pkg::YEAR_W-1:0];
      end
    end
  end

  logic [jdc_pkg::DN_W-1:0]      o_dn_r;
  logic [jdc_pkg::DAY_W-1:0]     o_day_r;
  logic [jdc_pkg::MON_W-1:0]     o_mon_r;
  logic [jdc_pkg::YEAR_W-1:0]    o_year_r;
  logic                          o_err_r;

  always_ff @(posedge clk) begin
    if (en7) begin
      o_dn_r   <= o_dn_nxt;
      o_day_r  <= o_day_nxt;
      o_mon_r  <= o_mon_nxt;
      o_year_r <= o_year_nxt;
      o_err_r  <= o_err_nxt;
    end
  end

  assign out_chan.valid          = v7_r;
  assign out_chan.day_number_out = o_dn_r;
  assign out_chan.day_out        = o_day_r;
  assign out_chan.month_out      = o_mon_r;
  assign out_chan.year_out       = o_year_r;
  assign out_chan.range_error    = o_err_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // An empty output register must leave the whole pipe open to a new request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v7_r |-> in_chan.ready)
    else $error("request refused while the output register is empty");

  // A date result carries a real day and month and no day number
  a_date_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (v7_r && (o_mon_r != '0)) |-> ((o_mon_r <= 4'd12) && (o_day_r != '0) && (o_dn_r == '0)))
    else $error("date result with bad month, day or stray day number");

  // A day number result leaves the date fields at zero
  a_number_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (v7_r && (o_dn_r != '0)) |-> ((o_day_r == '0) && (o_mon_r == '0) && (o_year_r == '0)))
    else $error("day number result with stray date fields");

  // A flagged date result holds a clamped year
  a_year_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (v7_r && o_err_r && (o_mon_r != '0)) |->
      ((o_year_r == '0) || (o_year_r == jdc_pkg::YEAR_MAX_V)))
    else $error("range error on a date result without a clamped year");

endmodule
